// ===== src/tti_pkg.sv =====
// Shared types and constants for the time table interpolator.
package tti_pkg;
    localparam int MAX_ROWS = 1024;
    localparam int MAX_CHANNELS = 8;
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CH_W = $clog2(MAX_CHANNELS);
    localparam int VAL_W = 48;
    localparam int ADDR_W = ROW_W + CH_W;
    localparam int ROWCNT_W = 11;
    localparam int CHCNT_W = 4;
    localparam int COL_W = 4;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_CHANS = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [ROW_W-1:0]        row_index;
        logic [COL_W-1:0]        column_index;
        logic signed [VAL_W-1:0] entry_value;
        logic signed [VAL_W-1:0] query_time;
    } req_t;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic signed [VAL_W-1:0] channel_value;
        logic                    last;
    } res_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_t;
endpackage

// ===== src/tti_if.sv =====
// Valid/ready channel interfaces.
interface tti_req_if;
    import tti_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tti_res_if;
    import tti_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tti_cfg_if;
    import tti_pkg::*;
    logic valid;
    logic ready;
    cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/tti_div.sv =====
// Restoring divider: round(a*b/d), one quotient bit per cycle.
module tti_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [49:0] a,
    input  logic [49:0] b,
    input  logic [49:0] d,
    output logic        done,
    output logic [49:0] q
);
    import tti_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M0 = 3'd1;
    localparam logic [2:0] S_M1 = 3'd2;
    localparam logic [2:0] S_M2 = 3'd3;
    localparam logic [2:0] S_M3 = 3'd4;
    localparam logic [2:0] S_DIV = 3'd5;

    logic [2:0]   st_reg;
    logic [6:0]   cnt_reg;
    logic [99:0]  num_reg;
    logic [50:0]  rem_reg;
    logic [49:0]  a_reg, b_reg, d_reg, q_reg;
    logic [24:0]  pa, pb;
    logic [49:0]  pp;
    logic [50:0]  trial;

    // 50x50 product built from four 25x25 partials, one per cycle
    always_comb
    begin
        case (st_reg)
            S_M0:    begin pa = a_reg[24:0];  pb = b_reg[24:0];  end
            S_M1:    begin pa = a_reg[24:0];  pb = b_reg[49:25]; end
            S_M2:    begin pa = a_reg[49:25]; pb = b_reg[24:0];  end
            default: begin pa = a_reg[49:25]; pb = b_reg[49:25]; end
        endcase
        pp = pa * pb;
        trial = {rem_reg[49:0], num_reg[99]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        a_reg <= a; b_reg <= b; d_reg <= d;
                        num_reg <= {51'd0, d[49:1]};
                        st_reg <= S_M0;
                    end
                end
                S_M0: begin num_reg <= num_reg + {50'd0, pp}; st_reg <= S_M1; end
                S_M1: begin num_reg <= num_reg + {25'd0, pp, 25'd0}; st_reg <= S_M2; end
                S_M2: begin num_reg <= num_reg + {25'd0, pp, 25'd0}; st_reg <= S_M3; end
                S_M3:
                begin
                    num_reg <= num_reg + {pp, 50'd0};
                    rem_reg <= '0;
                    q_reg <= '0;
                    cnt_reg <= 7'd100;
                    st_reg <= S_DIV;
                end
                S_DIV:
                begin
                    num_reg <= {num_reg[98:0], 1'b0};
                    if (trial >= {1'b0, d_reg})
                    begin
                        rem_reg <= trial - {1'b0, d_reg};
                        q_reg <= {q_reg[48:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial;
                        q_reg <= {q_reg[48:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        st_reg <= S_IDLE;
                        done <= 1'b1;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign q = q_reg;
endmodule

// ===== src/time_table_interpolator.sv =====
// Time table interpolator top level.
// Channels: req (loads and queries), res (per-channel results), cfg
// (register writes: 0 interpolate_mode, 1 row_count, 2 channel_count).
// A load writes one table word into the time or value memory and gives
// no result. A query scans the time memory one row per cycle, then per
// channel reads both row values and, in interpolate mode, runs a serial
// multiply/divide. Results leave through a single output register; the
// block waits for each result to be taken before the next channel
// proceeds, so a stalled receiver simply pauses it.
// One item is worked on at a time; req.ready is high only when idle.
// Reset clears the state, configuration and result-valid registers and
// the held outputs; the table memories are undefined until written and
// need no clearing pass.
module time_table_interpolator (
    input  logic clk,
    input  logic rst_n,
    tti_req_if.sink   req,
    tti_res_if.source res,
    tti_cfg_if.sink   cfg
);
    import tti_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_LAST  = 4'd3;
    localparam logic [3:0] S_RD0   = 4'd4;
    localparam logic [3:0] S_RD1   = 4'd5;
    localparam logic [3:0] S_CALC  = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;
    localparam logic [3:0] S_LOAD  = 4'd10;
    localparam logic [3:0] S_DSTART = 4'd11;

    logic [VAL_W-1:0] time_mem [MAX_ROWS];
    logic [VAL_W-1:0] val_mem [MAX_ROWS*MAX_CHANNELS];
    logic [VAL_W-1:0] t_rd, v_rd;
    logic [ROW_W-1:0] t_addr;
    logic [ADDR_W-1:0] v_addr;

    logic [3:0] st_reg;
    logic mode_reg;
    logic [ROWCNT_W-1:0] rows_reg;
    logic [CHCNT_W-1:0] chans_reg;
    logic [VAL_W-1:0] held_reg [MAX_CHANNELS];
    req_t item_reg;
    logic [ROW_W:0] idx_reg;          // scan row index
    logic signed [VAL_W-1:0] ta_reg, t0_reg, t1_reg, y0_reg, y1_reg;
    logic [CH_W-1:0] ch_reg;
    logic [1:0] how_reg;              // 0 held, 1 pair, 2 last row, 3 zero
    logic [ROW_W-1:0] lo_reg;
    logic res_valid_reg;
    res_t res_reg;
    logic div_start, div_done;
    logic [49:0] div_q;

    localparam logic [1:0] H_HELD = 2'd0;
    localparam logic [1:0] H_PAIR = 2'd1;
    localparam logic [1:0] H_LASTR = 2'd2;
    localparam logic [1:0] H_ZERO = 2'd3;

    logic [ROW_W:0] rows_eff;
    logic [CH_W:0] chans_eff;
    logic signed [VAL_W:0] dy, dt, dx;
    logic [49:0] dy_abs;
    logic signed [VAL_W+1:0] r_sum;
    logic signed [VAL_W-1:0] t_q;

    assign rows_eff = (rows_reg > ROWCNT_W'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS)
                                                       : rows_reg[ROW_W:0];
    assign chans_eff = (chans_reg == '0) ? (CH_W+1)'(1)
                     : (chans_reg > CHCNT_W'(MAX_CHANNELS)) ? (CH_W+1)'(MAX_CHANNELS)
                     : chans_reg[CH_W:0];
    assign t_q = item_reg.query_time;
    assign dy = {y1_reg[VAL_W-1], y1_reg} - {y0_reg[VAL_W-1], y0_reg};
    assign dt = {t1_reg[VAL_W-1], t1_reg} - {t0_reg[VAL_W-1], t0_reg};
    assign dx = {t_q[VAL_W-1], t_q} - {t0_reg[VAL_W-1], t0_reg};
    assign dy_abs = dy[VAL_W] ? 50'(-dy) : 50'(dy);
    // quotient never exceeds |dy|, so its low VAL_W+1 bits carry it
    assign r_sum = dy[VAL_W]
        ? ({{2{y0_reg[VAL_W-1]}}, y0_reg} - $signed({1'b0, div_q[VAL_W:0]}))
        : ({{2{y0_reg[VAL_W-1]}}, y0_reg} + $signed({1'b0, div_q[VAL_W:0]}));

    tti_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .a(dy_abs), .b(50'(dx)), .d(50'(dt)),
        .done(div_done), .q(div_q)
    );

    // memory addresses: lower row read in S_RD0, upper row in S_RD1
    always_comb
    begin
        t_addr = idx_reg[ROW_W-1:0];
        v_addr = {lo_reg, ch_reg};
        if (st_reg == S_RD1)
            v_addr = {lo_reg + ROW_W'(1), ch_reg};
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_LOAD && item_reg.column_index == '0)
            time_mem[item_reg.row_index] <= item_reg.entry_value;
        t_rd <= time_mem[t_addr];
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_LOAD && item_reg.column_index != '0
            && item_reg.column_index <= COL_W'(MAX_CHANNELS))
            val_mem[{item_reg.row_index, CH_W'(item_reg.column_index - COL_W'(1))}]
                <= item_reg.entry_value;
        v_rd <= val_mem[v_addr];
    end

    assign req.ready = (st_reg == S_IDLE);
    assign cfg.ready = (st_reg == S_IDLE);
    assign res.valid = res_valid_reg;
    assign res.data = res_reg;
    assign div_start = (st_reg == S_DSTART);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            mode_reg <= 1'b1;
            rows_reg <= '0;
            chans_reg <= CHCNT_W'(1);
            res_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_CHANNELS; k++)
                held_reg[k] <= '0;
        end
        else
        begin
            if (res.valid && res.ready)
                res_valid_reg <= 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.data.index)
                    REG_MODE:  mode_reg <= cfg.data.data[0];
                    REG_ROWS:  rows_reg <= cfg.data.data[ROWCNT_W-1:0];
                    REG_CHANS: chans_reg <= cfg.data.data[CHCNT_W-1:0];
                    default: ;
                endcase
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        item_reg <= req.data;
                        idx_reg <= '0;
                        ch_reg <= '0;
                        if (req.data.kind == KIND_LOAD)
                            st_reg <= S_LOAD;
                        else
                            st_reg <= S_SCAN;
                    end
                end
                S_LOAD: st_reg <= S_IDLE;
                S_SCAN:
                begin
                    // row 0 read issued; pairs checked in S_LAST
                    if (rows_eff == '0)
                    begin
                        how_reg <= H_ZERO;
                        st_reg <= S_RD0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        st_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    // t_rd holds time of row idx-1
                    if (idx_reg == rows_eff)
                    begin
                        if (t_q >= $signed(t_rd))
                        begin
                            how_reg <= H_LASTR;
                            lo_reg <= ROW_W'(idx_reg - 1'b1);
                        end
                        else
                            how_reg <= H_HELD;
                        st_reg <= S_RD0;
                    end
                    else
                    begin
                        ta_reg <= t_rd;
                        idx_reg <= idx_reg + 1'b1;
                        st_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    // t_rd holds time of row idx-1, ta_reg of idx-2
                    if (t_q >= ta_reg && t_q <= $signed(t_rd))
                    begin
                        how_reg <= H_PAIR;
                        lo_reg <= ROW_W'(idx_reg - 2'd2);
                        t0_reg <= ta_reg;
                        t1_reg <= t_rd;
                        st_reg <= S_RD0;
                    end
                    else if (idx_reg == rows_eff)
                    begin
                        if (t_q >= $signed(t_rd))
                        begin
                            how_reg <= H_LASTR;
                            lo_reg <= ROW_W'(idx_reg - 1'b1);
                        end
                        else
                            how_reg <= H_HELD;
                        st_reg <= S_RD0;
                    end
                    else
                    begin
                        ta_reg <= t_rd;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_RD0: st_reg <= S_RD1;   // lower row value read issued
                S_RD1:
                begin
                    y0_reg <= v_rd;
                    st_reg <= S_CALC;
                end
                S_CALC:
                begin
                    y1_reg <= v_rd;
                    if (how_reg == H_PAIR && mode_reg)
                        st_reg <= S_DSTART;
                    else
                    begin
                        case (how_reg)
                            H_ZERO:  held_reg[ch_reg] <= '0;
                            H_HELD:  ;
                            default: held_reg[ch_reg] <= y0_reg;
                        endcase
                        st_reg <= S_EMIT;
                    end
                end
                S_DSTART: st_reg <= S_DIVW;   // divider takes its operands here
                S_DIVW:
                begin
                    // equal times: lower row value
                    if (div_done)
                    begin
                        if (dt == '0)
                            held_reg[ch_reg] <= y0_reg;
                        else if (r_sum > $signed(50'sh7FFFFFFFFFFF))
                            held_reg[ch_reg] <= 48'h7FFFFFFFFFFF;
                        else if (r_sum < -$signed(50'sh800000000000))
                            held_reg[ch_reg] <= 48'h800000000000;
                        else
                            held_reg[ch_reg] <= r_sum[VAL_W-1:0];
                        st_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg.channel <= ch_reg;
                        res_reg.channel_value <= held_reg[ch_reg];
                        res_reg.last <= ({1'b0, ch_reg} + 1'b1 == chans_eff);
                        st_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (!res_valid_reg || res.ready)
                    begin
                        if ({1'b0, ch_reg} + 1'b1 == chans_eff)
                            st_reg <= S_IDLE;
                        else
                        begin
                            ch_reg <= ch_reg + 1'b1;
                            st_reg <= S_RD0;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !res_valid_reg || st_reg == S_IDLE)
        else $error("ready outside idle");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.data))
        else $error("result dropped");
    a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> st_reg == S_DIVW)
        else $error("divider done outside wait");
endmodule
